FILE: design/piq_pkg.sv
// ----------------------------------------------------------------------------
// piq_pkg : shared types for the point-in-quadrilateral obstacle test
// Coordinate, difference and product types, the sequencer states and the
// request bundle handed to the shared difference multiplier.
// ----------------------------------------------------------------------------
package piq_pkg;

    localparam int COORD_W = 14;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int REG_IDX_W = 4;
    localparam int REG_COUNT = 8;
    localparam int VERT_SLOTS = 4;
    localparam int SLOT_W = 2;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [DIFF_W-1:0]  t_diff;
    typedef logic signed [PROD_W-1:0]  t_prod;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_MUL_L,
        S_MUL_R,
        S_CMP,
        S_FIN
    } t_state;

    // Product request: (a_hi - a_lo) * (b_hi - b_lo), captured when en is set.
    typedef struct packed {
        logic   en;
        t_coord a_hi;
        t_coord a_lo;
        t_coord b_hi;
        t_coord b_lo;
    } t_mul_req;

endpackage

FILE: design/point_in_quad_obstacle_test_core.sv
// ----------------------------------------------------------------------------
// point_in_quad_obstacle_test_core : even-odd point-in-polygon test
// Tests obstacle points against a three- or four-vertex polygon held in
// configuration registers, reporting per point and per run whether a point
// lies inside.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  --------  ---------  -----------------------------------------------------
//  s_axis    in         tdata: point_x [13:0], point_y [27:14]; tlast: last
//  m_axis    out        tdata: point_inside [0], any_inside [1]; tlast: end
//  cfg       in         index 0..7 selects vertexN_x / vertexN_y, data 14 bits
//
//  Each point goes from acceptance through a load of the closing vertex,
//  then per edge two products on the single shared multiplier and a
//  compare, then a write of the result register and a return to idle
//  before the next point can be accepted.
//  Reset is synchronous and active low; it clears the vertices to the origin
//  and the run accumulator. A stalled result holds the block in idle, and
//  the input is not taken again until the result register can accept.
// ----------------------------------------------------------------------------
module point_in_quad_obstacle_test_core #(
    parameter int VERTEX_COUNT = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Input point stream
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [31:0]                       i_s_axis_tdata,  // point_x, point_y
    input  logic                              i_s_axis_tlast,
    // Result stream
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [7:0]                        o_m_axis_tdata,  // point_inside, any_inside
    output logic                              o_m_axis_tlast,
    // Configuration write channel
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [piq_pkg::REG_IDX_W-1:0]     i_cfg_index,
    input  logic [piq_pkg::COORD_W-1:0]       i_cfg_data
);
    import piq_pkg::*;

    localparam int EDGE_W = $clog2(VERTEX_COUNT);
    localparam logic [EDGE_W-1:0] LAST_EDGE = EDGE_W'(VERTEX_COUNT - 1);

    // Vertex registers, written from the configuration channel.
    t_coord r_vx [VERT_SLOTS];
    t_coord r_vy [VERT_SLOTS];

    // Sequencer state.
    t_state r_state;
    t_state n_state;
    logic [EDGE_W-1:0] r_edge;

    // Latched point and per-point working values.
    t_coord r_px;
    t_coord r_py;
    logic   r_last;
    t_coord r_prev_x;
    t_coord r_prev_y;
    t_prod  r_lhs;
    logic   r_straddle;
    logic   r_d_pos;
    logic   r_cross;
    logic   r_x_lo;
    logic   r_x_hi;
    logic   r_y_lo;
    logic   r_y_hi;
    logic   r_seen;

    // Result register.
    logic   r_out_valid;
    logic   r_out_inside;
    logic   r_out_any;
    logic   r_out_last;

    t_coord   w_cur_x;
    t_coord   w_cur_y;
    t_mul_req w_mul_req;
    t_prod    w_prod;
    logic     w_in_acc;
    logic     w_left;
    logic     w_inside;
    logic     w_cfg_acc;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_acc   = i_cfg_valid;

    // A beat is taken only in idle and only when the result register is
    // empty or draining, so a finished result always finds room.
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // The edge runs from the previous vertex to the current one.
    assign w_cur_x = r_vx[SLOT_W'(r_edge)];
    assign w_cur_y = r_vy[SLOT_W'(r_edge)];

    // The left-of test flips its sense with the sign of the edge's y extent.
    assign w_left   = r_d_pos ? (r_lhs < w_prod) : (r_lhs > w_prod);
    assign w_inside = r_cross && r_x_lo && r_x_hi && r_y_lo && r_y_hi;

    piq_mul_unit u_mul (
        .i_clk  (i_clk),
        .i_req  (w_mul_req),
        .o_prod (w_prod)
    );

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) begin
                n_state = S_LOAD;
            end
            S_LOAD:  n_state = S_MUL_L;
            S_MUL_L: n_state = S_MUL_R;
            S_MUL_R: n_state = S_CMP;
            S_CMP:   n_state = (r_edge == LAST_EDGE) ? S_FIN : S_MUL_L;
            S_FIN:   n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_mul_req = '0;
        unique case (r_state)
            S_MUL_L: begin
                // (px - xi) * (yj - yi)
                w_mul_req.en   = 1'b1;
                w_mul_req.a_hi = r_px;
                w_mul_req.a_lo = w_cur_x;
                w_mul_req.b_hi = r_prev_y;
                w_mul_req.b_lo = w_cur_y;
            end
            S_MUL_R: begin
                // (xj - xi) * (py - yi)
                w_mul_req.en   = 1'b1;
                w_mul_req.a_hi = r_prev_x;
                w_mul_req.a_lo = w_cur_x;
                w_mul_req.b_hi = r_py;
                w_mul_req.b_lo = w_cur_y;
            end
            default: w_mul_req = '0;
        endcase
    end

    // Configuration registers: even indices are x, odd are y.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < VERT_SLOTS; k++) begin
                r_vx[k] <= '0;
                r_vy[k] <= '0;
            end
        end else if (w_cfg_acc && (i_cfg_index < REG_IDX_W'(REG_COUNT))) begin
            if (i_cfg_index[0]) begin
                r_vy[i_cfg_index[SLOT_W:1]] <= i_cfg_data;
            end else begin
                r_vx[i_cfg_index[SLOT_W:1]] <= i_cfg_data;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN) begin
                r_out_valid <= 1'b1;
                r_seen      <= r_last ? 1'b0 : (r_seen || w_inside);
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_px   <= i_s_axis_tdata[COORD_W-1:0];
                    r_py   <= i_s_axis_tdata[2*COORD_W-1:COORD_W];
                    r_last <= i_s_axis_tlast;
                end
            end
            S_LOAD: begin
                // The first edge closes the polygon from its last vertex.
                r_prev_x <= r_vx[SLOT_W'(LAST_EDGE)];
                r_prev_y <= r_vy[SLOT_W'(LAST_EDGE)];
                r_edge   <= '0;
                r_cross  <= 1'b0;
                r_x_lo   <= 1'b0;
                r_x_hi   <= 1'b0;
                r_y_lo   <= 1'b0;
                r_y_hi   <= 1'b0;
            end
            S_MUL_L: begin
                // The box test holds when some vertex lies on each side of
                // the point in both axes; each vertex is visited once here.
                r_x_lo     <= r_x_lo || (w_cur_x <= r_px);
                r_x_hi     <= r_x_hi || (w_cur_x >= r_px);
                r_y_lo     <= r_y_lo || (w_cur_y <= r_py);
                r_y_hi     <= r_y_hi || (w_cur_y >= r_py);
                r_straddle <= (w_cur_y > r_py) != (r_prev_y > r_py);
                r_d_pos    <= r_prev_y > w_cur_y;
            end
            S_MUL_R: begin
                r_lhs <= w_prod;
            end
            S_CMP: begin
                if (r_straddle && w_left) begin
                    r_cross <= !r_cross;
                end
                r_prev_x <= w_cur_x;
                r_prev_y <= w_cur_y;
                r_edge   <= r_edge + 1'b1;
            end
            S_FIN: begin
                r_out_inside <= w_inside;
                r_out_any    <= r_seen || w_inside;
                r_out_last   <= r_last;
            end
            default: begin
            end
        endcase
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'b0, r_out_any, r_out_inside};
    assign o_m_axis_tlast  = r_out_last;

endmodule

FILE: design/piq_mul_unit.sv
// ----------------------------------------------------------------------------
// piq_mul_unit : shared difference multiplier
// Forms two coordinate differences and registers their signed product.
// ----------------------------------------------------------------------------
module piq_mul_unit (
    input  logic              i_clk,
    input  piq_pkg::t_mul_req i_req,
    output piq_pkg::t_prod    o_prod
);
    import piq_pkg::*;

    t_diff w_diff_a;
    t_diff w_diff_b;
    t_prod w_prod;
    t_prod r_prod;

    assign w_diff_a = t_diff'(i_req.a_hi) - t_diff'(i_req.a_lo);
    assign w_diff_b = t_diff'(i_req.b_hi) - t_diff'(i_req.b_lo);
    assign w_prod   = t_prod'(w_diff_a) * t_prod'(w_diff_b);

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= w_prod;
        end
    end

    assign o_prod = r_prod;

endmodule
